// ===== src/htu_pkg.sv =====
// Shared constants and types for the text box hit test unit.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package htu_pkg;

  // table geometry
  localparam int MAX_BOXES = 1024;
  localparam int ADDR_W    = $clog2(MAX_BOXES);
  localparam int COUNT_W   = ADDR_W + 1;

  // field widths
  localparam int COORD_W   = 20;
  localparam int SIZE_W    = COORD_W - 1;
  localparam int ENTRY_W   = 2 * COORD_W + 2 * SIZE_W;
  localparam int RES_W     = ADDR_W + 2;

  // doubled offset, its magnitude, square and sum of squares
  localparam int OFF_W     = COORD_W + 3;
  localparam int MAG_W     = OFF_W - 1;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 1;

  // pipeline stages after the read issue, minus one
  localparam int DRAIN_LAST = 2;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } htu_cmd_t;

endpackage

`default_nettype wire

// ===== src/text_box_hit_test_unit.sv =====
// Top level of the text box hit test unit: controller plus datapath.
// Depends on htu_pkg, htu_controller, htu_datapath (and htu_ram below it).
//
//   channel   handshake              payload
//   --------  ---------------------  ------------------------------------------
//   command   start_i / busy_o       cmd_i, box_index_i, box_left_i, box_top_i,
//                                    box_width_i, box_height_i, point_x_i,
//                                    point_y_i, inside_mode_i
//   result    done_o (one cycle)     found_index_o
//   config    cfg_we_i               cfg_wdata_i (box count)
//
// A transaction is taken at a clock edge with start_i high and busy_o low.
// A write transaction stores its entry at that edge and leaves busy_o low.
// A query scans the table with one read per cycle through the single table
// read port: busy_o stays high over the scan of n entries (n = box count capped
// at the table depth), the drain and the done_o cycle; n of zero skips to done_o.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// After reset the box count is zero; the table holds no defined data.
`default_nettype none

module text_box_hit_test_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic                                 cmd_i,
  input  wire logic [htu_pkg::ADDR_W-1:0]           box_index_i,
  input  wire logic signed [htu_pkg::COORD_W-1:0]   box_left_i,
  input  wire logic signed [htu_pkg::COORD_W-1:0]   box_top_i,
  input  wire logic [htu_pkg::SIZE_W-1:0]           box_width_i,
  input  wire logic [htu_pkg::SIZE_W-1:0]           box_height_i,
  input  wire logic signed [htu_pkg::COORD_W-1:0]   point_x_i,
  input  wire logic signed [htu_pkg::COORD_W-1:0]   point_y_i,
  input  wire logic                                 inside_mode_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [htu_pkg::COUNT_W-1:0]          cfg_wdata_i,
  output logic                                      done_o,
  output logic signed [htu_pkg::RES_W-1:0]          found_index_o
);

  import htu_pkg::*;

  htu_cmd_t cmd;

  // scan sequencer and box count
  htu_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  // table, distance pipeline and best tracker
  htu_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .box_index_i   (box_index_i),
    .box_left_i    (box_left_i),
    .box_top_i     (box_top_i),
    .box_width_i   (box_width_i),
    .box_height_i  (box_height_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .inside_mode_i (inside_mode_i),
    .found_index_o (found_index_o)
  );

endmodule

`default_nettype wire

// ===== src/htu_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module htu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/htu_datapath.sv =====
// Datapath of the hit test unit: box table, distance and containment pipeline,
// running best-box tracker. Depends on htu_pkg and htu_ram.
`default_nettype none

module htu_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire htu_pkg::htu_cmd_t                    cmd_i,
  input  wire logic [htu_pkg::ADDR_W-1:0]           box_index_i,
  input  wire logic signed [htu_pkg::COORD_W-1:0]   box_left_i,
  input  wire logic signed [htu_pkg::COORD_W-1:0]   box_top_i,
  input  wire logic [htu_pkg::SIZE_W-1:0]           box_width_i,
  input  wire logic [htu_pkg::SIZE_W-1:0]           box_height_i,
  input  wire logic signed [htu_pkg::COORD_W-1:0]   point_x_i,
  input  wire logic signed [htu_pkg::COORD_W-1:0]   point_y_i,
  input  wire logic                                 inside_mode_i,
  output logic signed [htu_pkg::RES_W-1:0]          found_index_o
);

  import htu_pkg::*;

  logic [ENTRY_W-1:0]        rdata;
  logic signed [COORD_W-1:0] px_q, py_q;
  logic                      mode_q;

  // stage 1: table output
  logic                      v1_q;
  logic [ADDR_W-1:0]         idx1_q;
  logic signed [COORD_W-1:0] b_left, b_top;
  logic [SIZE_W-1:0]         b_width, b_height;

  // stage 2: offsets and containment
  logic signed [OFF_W-1:0]   dx, dy;
  logic signed [COORD_W:0]   right_edge, bottom_edge;
  logic                      hit;
  logic                      v2_q, hit2_q, right2_q;
  logic [ADDR_W-1:0]         idx2_q;
  logic [MAG_W-1:0]          magx_q, magy_q;

  // stage 3: squares
  logic                      v3_q, hit3_q, right3_q;
  logic [ADDR_W-1:0]         idx3_q;
  logic [SQ_W-1:0]           sqx_q, sqy_q;
  logic [SUM_W-1:0]          dist_sum;

  // running best
  logic                      found_q;
  logic [SUM_W-1:0]          best_dist_q;
  logic [ADDR_W-1:0]         best_idx_q;
  logic                      best_right_q;
  logic                      take;

  // box table
  htu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BOXES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (box_index_i),
    .wdata_i ({box_left_i, box_top_i, box_width_i, box_height_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  // query point and mode captured when a query starts
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      mode_q <= inside_mode_i;
    end
  end

  // stage 1 tag: table data arrives in the cycle after the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= cmd_i.rd_addr;
  end

  assign {b_left, b_top, b_width, b_height} = rdata;

  // doubled center offsets and containment test
  always_comb begin
    dx = (OFF_W'(px_q) <<< 1) - (OFF_W'(b_left) <<< 1) - $signed({4'b0, b_width});
    dy = (OFF_W'(py_q) <<< 1) - (OFF_W'(b_top) <<< 1) - $signed({4'b0, b_height});
    right_edge  = (COORD_W+1)'(b_left) + $signed({2'b0, b_width});
    bottom_edge = (COORD_W+1)'(b_top) + $signed({2'b0, b_height});
    hit = (px_q >= b_left) && ((COORD_W+1)'(px_q) < right_edge) &&
          (py_q >= b_top) && ((COORD_W+1)'(py_q) < bottom_edge);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 2 registers: magnitudes of the offsets
  always_ff @(posedge clk_i) begin
    idx2_q   <= idx1_q;
    hit2_q   <= hit;
    right2_q <= (dx > 0);
    magx_q   <= dx[OFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    magy_q   <= dy[OFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  end

  // stage 3 registers: squares
  always_ff @(posedge clk_i) begin
    idx3_q   <= idx2_q;
    hit3_q   <= hit2_q;
    right3_q <= right2_q;
    sqx_q    <= magx_q * magx_q;
    sqy_q    <= magy_q * magy_q;
  end

  assign dist_sum = SUM_W'(sqx_q) + SUM_W'(sqy_q);

  // first hit wins in inside mode, strictly closer wins in nearest mode
  always_comb begin
    take = 1'b0;
    if (v3_q) begin
      if (mode_q) begin
        take = !found_q && hit3_q;
      end else begin
        take = !found_q || (dist_sum < best_dist_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dist_q  <= dist_sum;
      best_idx_q   <= idx3_q;
      best_right_q <= right3_q;
    end
  end

  // final index (all ones when none found), bumped in nearest mode when the point lies right of the nearest center
  always_comb begin
    if (!found_q) begin
      found_index_o = '1;
    end else begin
      found_index_o = $signed(RES_W'(best_idx_q) + RES_W'(best_right_q & ~mode_q));
    end
  end

endmodule

`default_nettype wire

// ===== src/htu_controller.sv =====
// Controller of the hit test unit: box count register, table scan sequencer
// and result strobe. Depends on htu_pkg.
`default_nettype none

module htu_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [htu_pkg::COUNT_W-1:0]   cfg_wdata_i,
  output htu_pkg::htu_cmd_t                  cmd_o,
  output logic                               busy_o,
  output logic                               done_o
);

  import htu_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_BOXES);

  logic [1:0]         state_q, state_d;
  logic [COUNT_W-1:0] box_count_q;
  logic [COUNT_W-1:0] n_q, n_d, n_eff;
  logic [COUNT_W-1:0] ctr_q, ctr_d;
  logic [1:0]         drain_q, drain_d;
  logic               accept;

  // box count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_count_q <= '0;
    end else if (cfg_we_i) begin
      box_count_q <= cfg_wdata_i;
    end
  end

  assign n_eff  = (box_count_q > COUNT_MAX) ? COUNT_MAX : box_count_q;
  assign accept = start_i && (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    ctr_d         = ctr_q;
    drain_d       = drain_q;
    cmd_o         = '0;
    cmd_o.rd_addr = ctr_q[ADDR_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i == CMD_WRITE) begin
          cmd_o.wr_en = 1'b1;
        end else if (accept && cmd_i == CMD_QUERY) begin
          cmd_o.load = 1'b1;
          n_d        = n_eff;
          ctr_d      = '0;
          state_d    = (n_eff == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (ctr_q == n_q - 1'b1) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == 2'(DRAIN_LAST)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      ctr_q   <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      ctr_q   <= ctr_d;
      drain_q <= drain_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  // a result strobe is always followed by an idle cycle
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("busy after result strobe");

  // table reads stay inside the entries in use
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (ctr_q < n_q) && (n_q <= COUNT_MAX))
    else $error("table read beyond box count");

  // a query over an empty table answers in the next cycle
  a_empty_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_QUERY && n_eff == '0) |=> done_o)
    else $error("empty query did not finish at once");

  // a table write never occupies the unit
  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_WRITE) |=> !busy_o)
    else $error("write transaction left unit busy");

endmodule

`default_nettype wire
